[rtl/ssfe_pkg.sv]
// ----------------------------------------------------------------------------
// ssfe_pkg: shared types and codes for the sorted multiset floor extractor
// Holds the input kind codes, result status codes, the sequencer states and
// the control bundle that the sequencer broadcasts to the cell row.
// ----------------------------------------------------------------------------
package ssfe_pkg;

  localparam int unsigned AmountBits = 30;
  localparam int unsigned StatusBits = 2;

  // Input kind codes carried on the slave-side tuser.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // Result status codes carried on the master-side tuser.
  typedef enum logic [StatusBits-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_TAKEN    = 2'd2,
    ST_NONE     = 2'd3
  } ssfe_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY,
    S_FIN
  } ssfe_state_e;

  // Per-cycle commands broadcast to every cell.
  typedef struct packed {
    logic cmp_en;   // latch the key compare in every cell
    logic ins_en;   // open a slot and shift the upper part right
    logic ext_en;   // drop the floor entry and shift the upper part left
  } ssfe_ctrl_t;

endpackage

[rtl/ssfe_cell.sv]
// ----------------------------------------------------------------------------
// ssfe_cell: one slot of the sorted row
// Holds one value, compares it with the broadcast key and moves data to or
// from its neighbors on insert and extract.
// ----------------------------------------------------------------------------
module ssfe_cell #(
  parameter int unsigned VALUE_BITS = 30,
  parameter int unsigned CNT_W      = 9,
  parameter int unsigned INDEX      = 0
) (
  input  logic                   clk_i,
  input  ssfe_pkg::ssfe_ctrl_t   ctrl_i,
  input  logic [VALUE_BITS-1:0]  key_i,
  input  logic [CNT_W-1:0]       count_i,
  input  logic [VALUE_BITS-1:0]  left_value_i,
  input  logic                   left_le_i,
  input  logic [VALUE_BITS-1:0]  right_value_i,
  input  logic                   right_le_i,
  output logic [VALUE_BITS-1:0]  value_o,
  output logic                   le_o,
  output logic [VALUE_BITS-1:0]  taken_o
);
  import ssfe_pkg::*;

  logic [VALUE_BITS-1:0] value_q, value_d;
  logic                  le_q, le_d;
  logic                  occupied;

  assign occupied = (CNT_W'(INDEX) < count_i);

  always_comb begin
    le_d    = le_q;
    value_d = value_q;
    if (ctrl_i.cmp_en) begin
      le_d = occupied && (value_q <= key_i);
    end
    if (ctrl_i.ins_en && !le_q) begin
      // The first slot above the key takes the key, the rest shift up.
      value_d = left_le_i ? key_i : left_value_i;
    end
    if (ctrl_i.ext_en && !right_le_i && !(INDEX == 0 && !le_q)) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    le_q    <= le_d;
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign le_o    = le_q;
  // The floor entry is the last slot that is not above the key.
  assign taken_o = (le_q && !right_le_i) ? value_q : '0;

endmodule

[rtl/ssfe_gather.sv]
// ----------------------------------------------------------------------------
// ssfe_gather: collects the floor value from the cell row
// At most one cell drives a nonzero value, so a registered two-level OR over
// groups of cells brings it to the output side.
// ----------------------------------------------------------------------------
module ssfe_gather #(
  parameter int unsigned N          = 256,
  parameter int unsigned VALUE_BITS = 30
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [VALUE_BITS-1:0] taken_i [N],
  output logic [VALUE_BITS-1:0] gathered_o
);
  import ssfe_pkg::*;

  localparam int unsigned Group = 16;
  localparam int unsigned NumGroups = (N + Group - 1) / Group;

  logic [VALUE_BITS-1:0] pad [NumGroups*Group];
  logic [VALUE_BITS-1:0] grp_q [NumGroups];
  logic [VALUE_BITS-1:0] grp_d [NumGroups];

  for (genvar p = 0; p < NumGroups * Group; p++) begin : g_pad
    if (p < N) begin : g_real
      assign pad[p] = taken_i[p];
    end else begin : g_zero
      assign pad[p] = '0;
    end
  end

  // First level: one OR per group of cells.
  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < Group; j++) begin
        grp_d[g] = grp_d[g] | pad[g*Group + j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g < NumGroups; g++) begin
        grp_q[g] <= grp_d[g];
      end
    end
  end

  always_comb begin
    gathered_o = '0;
    for (int g = 0; g < NumGroups; g++) begin
      gathered_o = gathered_o | grp_q[g];
    end
  end

endmodule

[rtl/sorted_multiset_floor_extract_top.sv]
// ----------------------------------------------------------------------------
// sorted_multiset_floor_extract_top: bounded sorted multiset with floor take
// A row of compare-and-shift cells keeps the values in ascending order; a
// small sequencer drives insert and floor-extract operations on the row.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the slave-side stream. tuser selects the operation: zero
//   inserts the value in tdata, one queries with tdata as an upper limit.
//   Every item yields exactly one result item on the master-side stream,
//   with a status code in tuser and, for a successful query, the removed
//   value in tdata (zero otherwise).
//   An item is handled in steps: the key is compared in
//   every cell at once, then the row shifts while the floor value enters a
//   registered OR tree, and then the result is loaded into the output
//   register. The sequencer works on one item at a time: it takes the next
//   item only once the result of the last one is in the output register.
//   The output register keeps the result while the receiver stalls, and a
//   new item is taken meanwhile; only its final step waits for the register.
//   Reset empties the store at once (the fill count is cleared); no
//   clearing pass runs and the first item is accepted right after reset.
//   Equal values keep arrival order; a query removes one copy of the largest
//   stored value not above its limit.
// ----------------------------------------------------------------------------
module sorted_multiset_floor_extract_top #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned VALUE_BITS = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [29:0] amount, [31:30] zero
  input  logic        s_axis_tuser_i,  // [0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [29:0] taken_value, [31:30] zero
  output logic [1:0]  m_axis_tuser_o   // [1:0] status
);
  import ssfe_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // Sequencer and item registers.
  ssfe_state_e           state_q, state_d;
  logic                  kind_q;
  logic [VALUE_BITS-1:0] key_q;
  logic [CntW-1:0]       count_q, count_d;
  ssfe_status_e          status_q, status_d;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  ssfe_status_e          out_status_q;
  logic [AmountBits-1:0] out_taken_q;

  ssfe_ctrl_t            ctrl;
  logic                  accept_in;
  logic                  load_out;
  logic                  full;
  logic                  found;

  // Amount to key and gathered value to result, each through a wide word so
  // that any value width is zero-extended or truncated cleanly.
  logic [VALUE_BITS+AmountBits-1:0] amount_wide;
  logic [VALUE_BITS+AmountBits-1:0] gathered_wide;
  logic [VALUE_BITS-1:0]            gathered;

  // Cell row.
  logic [VALUE_BITS-1:0] cell_value [CAPACITY];
  logic                  cell_le    [CAPACITY];
  logic [VALUE_BITS-1:0] cell_taken [CAPACITY];

  assign amount_wide   = {{VALUE_BITS{1'b0}}, s_axis_tdata_i[AmountBits-1:0]};
  assign gathered_wide = {{AmountBits{1'b0}}, gathered};

  assign accept_in       = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign full            = (count_q == CntW'(CAPACITY));
  assign found           = cell_le[0];
  assign load_out        = (state_q == S_FIN) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    status_d   = status_q;
    ctrl       = '0;
    case (state_q)
      S_IDLE: begin
        if (accept_in) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_d     = S_APPLY;
      end
      S_APPLY: begin
        if (kind_q == KIND_INSERT) begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            status_d    = ST_INSERTED;
            ctrl.ins_en = 1'b1;
            count_d     = count_q + CntW'(1);
          end
        end else begin
          if (found) begin
            status_d    = ST_TAKEN;
            ctrl.ext_en = 1'b1;
            count_d     = count_q - CntW'(1);
          end else begin
            status_d = ST_NONE;
          end
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      kind_q <= s_axis_tuser_i;
      key_q  <= amount_wide[VALUE_BITS-1:0];
    end
    status_q <= status_d;
  end

  // The row of cells; the lowest cell sees the key as its left neighbor, the
  // highest sees nothing above it.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_value;
    logic                  left_le;
    logic [VALUE_BITS-1:0] right_value;
    logic                  right_le;

    if (i == 0) begin : g_first
      assign left_value = key_q;
      assign left_le    = 1'b1;
    end else begin : g_mid
      assign left_value = cell_value[i-1];
      assign left_le    = cell_le[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = cell_value[i];
      assign right_le    = 1'b0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_le    = cell_le[i+1];
    end

    ssfe_cell #(
      .VALUE_BITS(VALUE_BITS),
      .CNT_W     (CntW),
      .INDEX     (i)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .key_i        (key_q),
      .count_i      (count_q),
      .left_value_i (left_value),
      .left_le_i    (left_le),
      .right_value_i(right_value),
      .right_le_i   (right_le),
      .value_o      (cell_value[i]),
      .le_o         (cell_le[i]),
      .taken_o      (cell_taken[i])
    );
  end

  ssfe_gather #(
    .N         (CAPACITY),
    .VALUE_BITS(VALUE_BITS)
  ) u_gather (
    .clk_i     (clk_i),
    .en_i      (state_q == S_APPLY),
    .taken_i   (cell_taken),
    .gathered_o(gathered)
  );

  // Output register: loaded at the end of an item, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= status_q;
      out_taken_q  <= (status_q == ST_TAKEN) ? gathered_wide[AmountBits-1:0] : '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {2'b00, out_taken_q};

`ifndef NO_ASSERTIONS
  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("fill count above capacity");

  // The fill count moves only in the shift step of an item.
  a_count_only_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_APPLY) |=> $stable(count_q))
    else $error("fill count changed outside the shift step");

  // A result that took nothing carries a zero value.
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != ST_TAKEN)) |-> (m_axis_tdata_o == '0))
    else $error("nonzero value on a result without a take");

  // An accepted item always starts with the compare step.
  a_accept_to_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> (state_q == S_CMP))
    else $error("accepted item did not reach the compare step");
`endif

endmodule
